FILE: rtl/core/ird_pkg.sv
// ird_pkg: shared types and codes for the indexed ring deque
// no dependencies
`timescale 1ns / 1ps

package ird_pkg;

    localparam logic [3:0] F_GET     = 4'd0;
    localparam logic [3:0] F_PUT     = 4'd1;
    localparam logic [3:0] F_INSERT  = 4'd2;
    localparam logic [3:0] F_ADD_LO  = 4'd3;
    localparam logic [3:0] F_ADD_HI  = 4'd4;
    localparam logic [3:0] F_REMOVE  = 4'd5;
    localparam logic [3:0] F_REM_LO  = 4'd6;
    localparam logic [3:0] F_REM_HI  = 4'd7;
    localparam logic [3:0] F_ROTATE  = 4'd8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LATCH,
        CMD_CHECK,
        CMD_CAPTURE,
        CMD_SHRD,
        CMD_SHWR,
        CMD_INSWR,
        CMD_FINISH
    } t_cmd;

    typedef enum logic [1:0] {
        CLS_DONE,
        CLS_READ,
        CLS_INS
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic rm_shift;
        logic more;
    } t_dp_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CAPTURE,
        S_LOOP,
        S_SHRD,
        S_SHWR,
        S_INSWR,
        S_FINISH
    } t_state;

endpackage

FILE: rtl/core/ird_ctrl.sv
// ird_ctrl: sequencer for the ring deque
// depends on ird_pkg
`timescale 1ns / 1ps

module ird_ctrl import ird_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_IDLE;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd = CMD_CHECK;
                case (i_status.cls)
                    CLS_READ: n_state = S_CAPTURE;
                    CLS_INS:  n_state = S_LOOP;
                    default:  n_state = S_FINISH;
                endcase
            end
            S_CAPTURE: begin
                o_cmd   = CMD_CAPTURE;
                n_state = i_status.rm_shift ? S_LOOP : S_FINISH;
            end
            S_LOOP: begin
                // shift loop runs until the counter meets its bound
                if (i_status.more) begin
                    n_state = S_SHRD;
                end else if (i_status.rm_shift) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_INSWR;
                end
            end
            S_SHRD: begin
                o_cmd   = CMD_SHRD;
                n_state = S_SHWR;
            end
            S_SHWR: begin
                o_cmd   = CMD_SHWR;
                n_state = S_LOOP;
            end
            S_INSWR: begin
                o_cmd   = CMD_INSWR;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/ird_dp.sv
// ird_dp: slot memory, head pointer, element count and request checks
// depends on ird_pkg
`timescale 1ns / 1ps

module ird_dp import ird_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [3:0]        i_func,
    input  logic signed [7:0] i_position,
    input  logic [31:0]       i_data_word,
    output t_dp_status        o_status,
    output logic              o_strobe,
    output logic [31:0]       o_read_word,
    output logic [6:0]        o_count,
    output logic [1:0]        o_st
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > 8) ? CW : 8) + 2;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_q;

    logic [3:0]            r_func;
    logic signed [7:0]     r_pos;
    logic [WORD_WIDTH-1:0] r_data;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_j;
    logic [CW-1:0]         r_k;
    logic                  r_ins;
    logic [WORD_WIDTH-1:0] r_rd;
    t_status               r_st;
    t_cls                  r_cls;
    logic                  r_strobe;
    logic [31:0]           r_out_word;
    logic [6:0]            r_out_cnt;
    logic [1:0]            r_out_st;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(k);
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // request checks on the latched request
    logic signed [SW-1:0] s_pos, s_len;
    logic                 c_empty, c_full, c_idx_bad, c_ins_bad, c_rot_bad;
    logic                 c_front, c_back;
    t_status              c_st;
    t_cls                 c_cls;
    logic                 c_addlo, c_rot;
    logic signed [SW-1:0] c_js;
    logic [CW-1:0]        c_j, c_rot_i;
    logic [AW-1:0]        head_dec;

    always_comb begin
        s_pos     = {{(SW-8){r_pos[7]}}, r_pos};
        s_len     = {{(SW-CW){1'b0}}, r_cnt};
        c_empty   = (r_cnt == '0);
        c_full    = (r_cnt == CW'(DEPTH));
        c_idx_bad = (s_pos < 0) || (s_pos >= s_len);
        c_ins_bad = (s_pos < -s_len) || (s_pos > s_len + 1);
        c_rot_bad = (s_pos < -s_len) || (s_pos > s_len);
        c_front   = (s_pos == 1) || (s_pos == -s_len);
        c_back    = (s_pos == 0) || (s_pos == s_len + 1);
        head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
        c_st      = ST_OK;
        c_cls     = CLS_DONE;
        c_addlo   = 1'b0;
        c_rot     = 1'b0;
        c_js      = s_pos;
        c_rot_i   = '0;
        case (r_func)
            F_GET, F_PUT, F_REMOVE: begin
                if (c_empty) c_st = ST_EMPTY;
                else if (c_idx_bad) c_st = ST_INDEX;
                else c_cls = CLS_READ;
            end
            F_INSERT: begin
                if (c_full) c_st = ST_FULL;
                else if (c_ins_bad) c_st = ST_INDEX;
                else if (c_front) c_addlo = 1'b1;
                else begin
                    c_cls = CLS_INS;
                    if (c_back) c_js = s_len;
                    else if (s_pos < 0) c_js = s_pos + s_len;
                    else c_js = SW'(s_pos - 1);
                end
            end
            F_ADD_LO: begin
                if (c_full) c_st = ST_FULL;
                else c_addlo = 1'b1;
            end
            F_ADD_HI: begin
                if (c_full) c_st = ST_FULL;
                else begin
                    c_cls = CLS_INS;
                    c_js  = s_len;
                end
            end
            F_REM_LO: begin
                if (c_empty) c_st = ST_EMPTY;
                else begin
                    c_cls = CLS_READ;
                    c_js  = '0;
                end
            end
            F_REM_HI: begin
                if (c_empty) c_st = ST_EMPTY;
                else begin
                    c_cls = CLS_READ;
                    c_js  = SW'(s_len - 1);
                end
            end
            F_ROTATE: begin
                if (c_empty) c_st = ST_EMPTY;
                else if (c_rot_bad) c_st = ST_INDEX;
                else begin
                    c_rot = 1'b1;
                    // pos mod len with pos in 0..len is pos, or zero at len
                    if (s_pos < 0) c_rot_i = CW'(s_pos + s_len);
                    else if (s_pos == s_len) c_rot_i = '0;
                    else c_rot_i = CW'(s_pos);
                end
            end
            default: ;
        endcase
        c_j = c_js[CW-1:0];
    end

    logic rm_shift;
    assign rm_shift = (r_func == F_REMOVE) || (r_func == F_REM_HI);

    always_comb begin
        o_status.cls      = (i_cmd == CMD_CHECK) ? c_cls : r_cls;
        o_status.rm_shift = rm_shift && (r_cls == CLS_READ) && !r_ins;
        o_status.more     = r_ins ? (r_k > r_j) : (r_k < r_cnt);
    end

    // memory ports
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = slot_of(r_head, c_j);
        wr_en   = 1'b0;
        wr_addr = slot_of(r_head, r_j);
        wr_data = r_data;
        case (i_cmd)
            CMD_CHECK: begin
                rd_en = (c_cls == CLS_READ);
                if (c_addlo) begin
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                end
            end
            CMD_CAPTURE: begin
                wr_en = (r_func == F_PUT);
            end
            CMD_SHRD: begin
                rd_en   = 1'b1;
                rd_addr = r_ins ? slot_of(r_head, r_k - 1'b1) : slot_of(r_head, r_k + 1'b1);
            end
            CMD_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = slot_of(r_head, r_k);
                wr_data = r_q;
            end
            CMD_INSWR: begin
                wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    logic [63:0] data_ext, rd_ext;
    logic [15:0] cnt_ext;
    assign data_ext = 64'(i_data_word);
    assign rd_ext   = 64'(r_rd);
    assign cnt_ext  = 16'(r_cnt);

    // request registers and result
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_func <= i_func;
                r_pos  <= i_position;
                r_data <= data_ext[WORD_WIDTH-1:0];
            end
            CMD_CHECK: begin
                r_st  <= c_st;
                r_cls <= c_cls;
                r_j   <= c_j;
                r_k   <= r_cnt;
                r_ins <= (c_cls == CLS_INS);
                r_rd  <= c_addlo ? r_data : '0;
            end
            CMD_CAPTURE: begin
                r_rd <= r_q;
                r_k  <= r_j;
            end
            CMD_SHWR: begin
                r_k <= r_ins ? r_k - 1'b1 : r_k + 1'b1;
            end
            CMD_INSWR: begin
                r_rd <= r_data;
            end
            CMD_FINISH: begin
                r_out_word <= rd_ext[31:0];
                r_out_cnt  <= cnt_ext[6:0];
                r_out_st   <= r_st;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd == CMD_FINISH);
            case (i_cmd)
                CMD_CHECK: begin
                    if (c_addlo) begin
                        r_head <= head_dec;
                        r_cnt  <= r_cnt + 1'b1;
                    end else if (c_rot) begin
                        r_head <= slot_of(r_head, c_rot_i);
                    end
                end
                CMD_CAPTURE: begin
                    if (r_func == F_REM_LO) begin
                        r_head <= slot_of(r_head, CW'(1));
                        r_cnt  <= r_cnt - 1'b1;
                    end else if (rm_shift) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                CMD_INSWR: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_read_word = r_out_word;
    assign o_count     = r_out_cnt;
    assign o_st        = r_out_st;

endmodule

FILE: rtl/core/indexed_ring_deque_unit.sv
// indexed_ring_deque_unit: bounded circular deque with indexed get, put, insert, remove
// and rotate; depends on ird_pkg, ird_ctrl, ird_dp
// a middle insert or remove shifts entries one at a time, each by a memory read then write
// one request at a time, the next taken during the strobe; reset clears head, count, strobe
// and sequencer state only
`timescale 1ns / 1ps

module indexed_ring_deque_unit import ird_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        i_func,
    input  logic signed [7:0] i_position,
    input  logic [31:0]       i_data_word,
    output logic              o_strobe,
    output logic [31:0]       o_read_word,
    output logic [6:0]        o_count,
    output logic [1:0]        o_status
);

    t_cmd       cmd;
    t_dp_status dp_status;

    ird_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ird_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_data_word (i_data_word),
        .o_status    (dp_status),
        .o_strobe    (o_strobe),
        .o_read_word (o_read_word),
        .o_count     (o_count),
        .o_st        (o_status)
    );

endmodule
